// ----- hdl/fpp_pkg.sv -----
// Package for the frame phase profiler: default sizes, command and
// operation codes, and the word types of the input, queue and result sides.
// Used by every module of the block; depends on nothing.
`default_nettype none
package fpp_pkg;

    localparam int DEF_PHASE_CHANNELS  = 4;
    localparam int DEF_RASTER_CHANNELS = 4;
    localparam int Q_DEPTH             = 2;

    typedef enum logic [3:0] {
        CMD_FRAME_BEGIN = 4'd0,
        CMD_CH_BEGIN    = 4'd1,
        CMD_CH_END      = 4'd2,
        CMD_BLIT        = 4'd3,
        CMD_REPAINT     = 4'd4,
        CMD_FRAME_END   = 4'd5,
        CMD_RESET       = 4'd6,
        CMD_READ_LAST   = 4'd7,
        CMD_READ_WORST  = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        OP_BEGIN    = 3'd0,
        OP_CH_BEGIN = 3'd1,
        OP_CH_END   = 3'd2,
        OP_BLIT     = 3'd3,
        OP_REPAINT  = 3'd4,
        OP_END      = 3'd5,
        OP_RESET    = 3'd6,
        OP_READ     = 3'd7
    } op_code_t;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [31:0]        now_time;
        logic [2:0]         channel;
        logic [31:0]        blit_time;
        logic [31:0]        blit_pixels;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } item_t;

    typedef struct packed {
        logic        has_record;
        logic [4:0]  word_index;
        logic [31:0] word_value;
        logic        last_word;
    } result_t;

    // Repaint packs x and y into arg_a, w and h into arg_b.
    typedef struct packed {
        op_code_t    op;
        logic        worst;
        logic [31:0] now_time;
        logic [2:0]  channel;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
    } op_t;

endpackage
`default_nettype wire

// ----- hdl/frame_phase_profiler_top.sv -----
// Top level of the frame phase profiler: front end, operation queue and back end.
// Depends on fpp_pkg, fpp_front, fpp_queue and fpp_back.
//
//   Channel   Handshake     Word type          Direction
//   item      push / full   fpp_pkg::item_t    in
//   result    pop / empty   fpp_pkg::result_t  out
//
// Most words are handled in the idle state of the back end; a repaint
// then passes through the repaint state, and a frame end through the channel
// close, clamp, phase sum and finish sequences of the back end.
// A read gives one result word per cycle while the result side keeps popping.
// The two-entry queue lets the front accept words while the back end works.
// Reset clears control state and all records at once; no clearing pass.
`default_nettype none
module frame_phase_profiler_top #(
    parameter int PHASE_CHANNELS  = fpp_pkg::DEF_PHASE_CHANNELS,
    parameter int RASTER_CHANNELS = fpp_pkg::DEF_RASTER_CHANNELS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire fpp_pkg::item_t   item,
    output logic                  empty,
    input  wire logic             pop,
    output fpp_pkg::result_t      result
);

    logic         q_full;
    logic         q_push;
    logic         q_empty;
    logic         q_pop;
    fpp_pkg::op_t q_wr_data;
    fpp_pkg::op_t q_rd_data;

    fpp_front #(
        .PHASE_CHANNELS  (PHASE_CHANNELS),
        .RASTER_CHANNELS (RASTER_CHANNELS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    fpp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    fpp_back #(
        .PHASE_CHANNELS  (PHASE_CHANNELS),
        .RASTER_CHANNELS (RASTER_CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- hdl/fpp_front.sv -----
// Front end of the frame phase profiler: accepts words, tracks whether a
// frame is open and turns each useful word into an operation for the queue.
// Depends on fpp_pkg.
`default_nettype none
module fpp_front #(
    parameter int PHASE_CHANNELS  = fpp_pkg::DEF_PHASE_CHANNELS,
    parameter int RASTER_CHANNELS = fpp_pkg::DEF_RASTER_CHANNELS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire fpp_pkg::item_t item,
    input  wire logic           q_full,
    output logic                q_push,
    output fpp_pkg::op_t        q_data
);

    localparam int NUM_CH = PHASE_CHANNELS + RASTER_CHANNELS;

    logic frame_open_reg;
    logic frame_open_next;
    logic accept;
    logic keep;
    logic ch_ok;
    logic rect_ok;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign ch_ok   = (int'(item.channel) < NUM_CH);
    assign rect_ok = (item.rect_w > 16'sd0) && (item.rect_h > 16'sd0);

    always_comb
    begin
        keep            = 1'b0;
        frame_open_next = frame_open_reg;
        q_data.op       = fpp_pkg::OP_BEGIN;
        q_data.worst    = 1'b0;
        q_data.now_time = item.now_time;
        q_data.channel  = item.channel;
        q_data.arg_a    = item.blit_time;
        q_data.arg_b    = item.blit_pixels;
        unique case (fpp_pkg::cmd_t'(item.cmd))
            fpp_pkg::CMD_FRAME_BEGIN:
            begin
                keep            = 1'b1;
                frame_open_next = 1'b1;
            end
            fpp_pkg::CMD_CH_BEGIN:
            begin
                keep      = frame_open_reg && ch_ok;
                q_data.op = fpp_pkg::OP_CH_BEGIN;
            end
            fpp_pkg::CMD_CH_END:
            begin
                keep      = frame_open_reg && ch_ok;
                q_data.op = fpp_pkg::OP_CH_END;
            end
            fpp_pkg::CMD_BLIT:
            begin
                keep      = frame_open_reg;
                q_data.op = fpp_pkg::OP_BLIT;
            end
            fpp_pkg::CMD_REPAINT:
            begin
                keep         = frame_open_reg && rect_ok;
                q_data.op    = fpp_pkg::OP_REPAINT;
                q_data.arg_a = {item.rect_x, item.rect_y};
                q_data.arg_b = {item.rect_w, item.rect_h};
            end
            fpp_pkg::CMD_FRAME_END:
            begin
                keep            = frame_open_reg;
                q_data.op       = fpp_pkg::OP_END;
                frame_open_next = 1'b0;
            end
            fpp_pkg::CMD_RESET:
            begin
                keep      = 1'b1;
                q_data.op = fpp_pkg::OP_RESET;
            end
            fpp_pkg::CMD_READ_LAST:
            begin
                keep      = 1'b1;
                q_data.op = fpp_pkg::OP_READ;
            end
            fpp_pkg::CMD_READ_WORST:
            begin
                keep         = 1'b1;
                q_data.op    = fpp_pkg::OP_READ;
                q_data.worst = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fpp_queue.sv -----
// Short operation queue between the front and back ends of the profiler.
// Depends on fpp_pkg.
`default_nettype none
module fpp_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire fpp_pkg::op_t wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output fpp_pkg::op_t      rd_data,
    output logic              empty
);

    localparam int PW = (fpp_pkg::Q_DEPTH > 1) ? $clog2(fpp_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(fpp_pkg::Q_DEPTH + 1);

    fpp_pkg::op_t mem_reg [fpp_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(fpp_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(fpp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(fpp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fpp_back.sv -----
// Back end of the frame phase profiler: runs queued operations on the
// channel timers and records, and streams records out through a result register.
// Depends on fpp_pkg.
`default_nettype none
module fpp_back #(
    parameter int PHASE_CHANNELS  = fpp_pkg::DEF_PHASE_CHANNELS,
    parameter int RASTER_CHANNELS = fpp_pkg::DEF_RASTER_CHANNELS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fpp_pkg::op_t q_data,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              empty,
    input  wire logic         pop,
    output fpp_pkg::result_t  result
);

    localparam int NUM_CH    = PHASE_CHANNELS + RASTER_CHANNELS;
    localparam int W_INDEX   = 0;
    localparam int W_FRAME   = 1;
    localparam int W_PHASE   = 2;
    localparam int W_RASTER  = W_PHASE + PHASE_CHANNELS;
    localparam int W_RENDER  = W_RASTER + 1;
    localparam int W_BLIT    = W_RASTER + 2;
    localparam int W_OTHER   = W_RASTER + RASTER_CHANNELS;
    localparam int W_BLITPX  = W_OTHER + 1;
    localparam int W_DX      = W_BLITPX + 1;
    localparam int W_DY      = W_DX + 1;
    localparam int W_DW      = W_DY + 1;
    localparam int W_DH      = W_DW + 1;
    localparam int W_DPX     = W_DH + 1;
    localparam int REC_WORDS = W_DPX + 1;
    localparam int RW        = $clog2(REC_WORDS);
    localparam int CHW       = $clog2(NUM_CH);
    localparam int SUMW      = 32 + $clog2(PHASE_CHANNELS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_REP   = 7'b0000010,
        ST_CLOSE = 7'b0000100,
        ST_CLAMP = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_READ  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [RW-1:0] cnt_reg;
    logic [RW-1:0] cnt_next;
    fpp_pkg::op_t cur_reg;
    fpp_pkg::op_t cur_next;

    logic [31:0] rec_reg   [REC_WORDS];
    logic [31:0] rec_next  [REC_WORDS];
    logic [31:0] last_reg  [REC_WORDS];
    logic [31:0] last_next [REC_WORDS];
    logic [31:0] worst_reg [REC_WORDS];
    logic [31:0] worst_next[REC_WORDS];
    logic [31:0] fin_rec   [REC_WORDS];
    logic [31:0] start_reg [NUM_CH];
    logic [31:0] start_next[NUM_CH];
    logic [NUM_CH-1:0] run_reg;
    logic [NUM_CH-1:0] run_next;

    logic have_last_reg;
    logic have_last_next;
    logic have_worst_reg;
    logic have_worst_next;
    logic dirty_reg;
    logic dirty_next;
    logic [31:0] frame_num_reg;
    logic [31:0] frame_num_next;
    logic [31:0] fstart_reg;
    logic [31:0] fstart_next;
    logic [31:0] ft_reg;
    logic [31:0] ft_next;
    logic [SUMW-1:0] acc_reg;
    logic [SUMW-1:0] acc_next;

    logic [29:0] prod_reg;
    logic [29:0] prod_next;
    logic signed [33:0] x1_reg;
    logic signed [33:0] x1_next;
    logic signed [33:0] y1_reg;
    logic signed [33:0] y1_next;
    logic signed [33:0] xe_reg;
    logic signed [33:0] xe_next;
    logic signed [33:0] ye_reg;
    logic signed [33:0] ye_next;

    logic out_valid_reg;
    logic out_valid_next;
    fpp_pkg::result_t out_reg;
    fpp_pkg::result_t out_next;

    logic [CHW-1:0] head_ch;
    logic [CHW-1:0] cnt_ch;
    logic [RW-1:0]  head_idx;
    logic [RW-1:0]  cnt_idx;
    logic [RW-1:0]  sum_idx;
    logic slot_free;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] hw;
    logic signed [15:0] hh;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cw;
    logic signed [15:0] ch;
    logic signed [33:0] cx_s;
    logic signed [33:0] cy_s;
    logic signed [33:0] dx_s;
    logic signed [33:0] dy_s;
    logic signed [33:0] nx0;
    logic signed [33:0] ny0;
    logic signed [33:0] nx1;
    logic signed [33:0] ny1;
    logic signed [33:0] nw;
    logic signed [33:0] nh;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;

    assign head_ch  = CHW'(q_data.channel);
    assign cnt_ch   = cnt_reg[CHW-1:0];
    assign head_idx = RW'(W_PHASE) + RW'(head_ch);
    assign cnt_idx  = RW'(W_PHASE) + RW'(cnt_ch);
    assign sum_idx  = RW'(W_PHASE) + cnt_reg;

    assign hx = q_data.arg_a[31:16];
    assign hy = q_data.arg_a[15:0];
    assign hw = q_data.arg_b[31:16];
    assign hh = q_data.arg_b[15:0];
    assign cx = cur_reg.arg_a[31:16];
    assign cy = cur_reg.arg_a[15:0];
    assign cw = cur_reg.arg_b[31:16];
    assign ch = cur_reg.arg_b[15:0];

    assign cx_s = {{18{cx[15]}}, cx};
    assign cy_s = {{18{cy[15]}}, cy};
    assign dx_s = $signed({{2{rec_reg[W_DX][31]}}, rec_reg[W_DX]});
    assign dy_s = $signed({{2{rec_reg[W_DY][31]}}, rec_reg[W_DY]});
    assign nx0  = (cx_s < dx_s) ? cx_s : dx_s;
    assign ny0  = (cy_s < dy_s) ? cy_s : dy_s;
    assign nx1  = (xe_reg > x1_reg) ? xe_reg : x1_reg;
    assign ny1  = (ye_reg > y1_reg) ? ye_reg : y1_reg;
    assign nw   = nx1 - nx0;
    assign nh   = ny1 - ny0;

    always_comb
    begin
        for (int i = 0; i < REC_WORDS; i++)
        begin
            fin_rec[i] = rec_reg[i];
        end
        fin_rec[W_FRAME] = ft_reg;
        fin_rec[W_OTHER] = (SUMW'(ft_reg) > acc_reg) ? ft_reg - acc_reg[31:0] : 32'd0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        rec_next        = rec_reg;
        last_next       = last_reg;
        worst_next      = worst_reg;
        start_next      = start_reg;
        run_next        = run_reg;
        have_last_next  = have_last_reg;
        have_worst_next = have_worst_reg;
        dirty_next      = dirty_reg;
        frame_num_next  = frame_num_reg;
        fstart_next     = fstart_reg;
        ft_next         = ft_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        xe_next         = xe_reg;
        ye_next         = ye_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    cnt_next = '0;
                    unique case (q_data.op)
                        fpp_pkg::OP_BEGIN:
                        begin
                            for (int i = 0; i < REC_WORDS; i++)
                            begin
                                rec_next[i] = '0;
                            end
                            rec_next[W_INDEX] = frame_num_reg;
                            frame_num_next    = frame_num_reg + 32'd1;
                            run_next          = '0;
                            dirty_next        = 1'b0;
                            fstart_next       = q_data.now_time;
                        end
                        fpp_pkg::OP_CH_BEGIN:
                        begin
                            start_next[head_ch] = q_data.now_time;
                            run_next[head_ch]   = 1'b1;
                        end
                        fpp_pkg::OP_CH_END:
                        begin
                            if (run_reg[head_ch])
                            begin
                                rec_next[head_idx] = rec_reg[head_idx]
                                    + (q_data.now_time - start_reg[head_ch]);
                                run_next[head_ch] = 1'b0;
                            end
                        end
                        fpp_pkg::OP_BLIT:
                        begin
                            rec_next[W_BLIT]   = rec_reg[W_BLIT] + q_data.arg_a;
                            rec_next[W_BLITPX] = rec_reg[W_BLITPX] + q_data.arg_b;
                        end
                        fpp_pkg::OP_REPAINT:
                        begin
                            prod_next  = 30'(hw[14:0]) * 30'(hh[14:0]);
                            x1_next    = $signed({{2{rec_reg[W_DX][31]}}, rec_reg[W_DX]})
                                       + $signed({{2{rec_reg[W_DW][31]}}, rec_reg[W_DW]});
                            y1_next    = $signed({{2{rec_reg[W_DY][31]}}, rec_reg[W_DY]})
                                       + $signed({{2{rec_reg[W_DH][31]}}, rec_reg[W_DH]});
                            xe_next    = $signed({{18{hx[15]}}, hx}) + $signed({{18{hw[15]}}, hw});
                            ye_next    = $signed({{18{hy[15]}}, hy}) + $signed({{18{hh[15]}}, hh});
                            state_next = ST_REP;
                        end
                        fpp_pkg::OP_END:
                        begin
                            state_next = ST_CLOSE;
                        end
                        fpp_pkg::OP_RESET:
                        begin
                            for (int i = 0; i < REC_WORDS; i++)
                            begin
                                last_next[i]  = '0;
                                worst_next[i] = '0;
                            end
                            have_last_next  = 1'b0;
                            have_worst_next = 1'b0;
                            frame_num_next  = '0;
                        end
                        fpp_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REP:
            begin
                if (!dirty_reg)
                begin
                    rec_next[W_DX] = {{16{cx[15]}}, cx};
                    rec_next[W_DY] = {{16{cy[15]}}, cy};
                    rec_next[W_DW] = {{16{cw[15]}}, cw};
                    rec_next[W_DH] = {{16{ch[15]}}, ch};
                end
                else
                begin
                    rec_next[W_DX] = nx0[31:0];
                    rec_next[W_DY] = ny0[31:0];
                    rec_next[W_DW] = nw[31:0];
                    rec_next[W_DH] = nh[31:0];
                end
                dirty_next      = 1'b1;
                rec_next[W_DPX] = rec_reg[W_DPX] + 32'(prod_reg);
                state_next      = ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (run_reg[cnt_ch])
                begin
                    rec_next[cnt_idx] = rec_reg[cnt_idx] + (cur_reg.now_time - start_reg[cnt_ch]);
                    run_next[cnt_ch]  = 1'b0;
                end
                if (cnt_reg == RW'(NUM_CH - 1))
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLAMP:
            begin
                rec_next[W_RENDER] = (rec_reg[W_RENDER] > rec_reg[W_BLIT])
                                   ? rec_reg[W_RENDER] - rec_reg[W_BLIT] : 32'd0;
                ft_next    = cur_reg.now_time - fstart_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next = acc_reg + SUMW'(rec_reg[sum_idx]);
                if (cnt_reg == RW'(PHASE_CHANNELS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                rec_next[W_FRAME] = fin_rec[W_FRAME];
                rec_next[W_OTHER] = fin_rec[W_OTHER];
                last_next         = fin_rec;
                have_last_next    = 1'b1;
                if (!have_worst_reg || (ft_reg > worst_reg[W_FRAME]))
                begin
                    worst_next      = fin_rec;
                    have_worst_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.has_record = cur_reg.worst ? have_worst_reg : have_last_reg;
                    out_next.word_index = 5'(cnt_reg);
                    out_next.last_word  = (cnt_reg == RW'(REC_WORDS - 1));
                    if (cur_reg.worst)
                    begin
                        out_next.word_value = have_worst_reg ? worst_reg[cnt_reg] : 32'd0;
                    end
                    else
                    begin
                        out_next.word_value = have_last_reg ? last_reg[cnt_reg] : 32'd0;
                    end
                    if (cnt_reg == RW'(REC_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        ft_reg     <= ft_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        out_reg    <= out_next;
        start_reg  <= start_next;
        fstart_reg <= fstart_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            run_reg        <= '0;
            have_last_reg  <= 1'b0;
            have_worst_reg <= 1'b0;
            dirty_reg      <= 1'b0;
            frame_num_reg  <= '0;
            for (int i = 0; i < REC_WORDS; i++)
            begin
                rec_reg[i]   <= '0;
                last_reg[i]  <= '0;
                worst_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            run_reg        <= run_next;
            have_last_reg  <= have_last_next;
            have_worst_reg <= have_worst_next;
            dirty_reg      <= dirty_next;
            frame_num_reg  <= frame_num_next;
            rec_reg        <= rec_next;
            last_reg       <= last_next;
            worst_reg      <= worst_next;
        end
    end

endmodule
`default_nettype wire
